// ===== src/lae_pkg.sv =====
// Package for the linear ADSR envelope: widths, full-scale constant,
// stage codes and the request/step structs. No dependencies.
`timescale 1ns / 1ps

package lae_pkg;

    localparam int FULL_SCALE_BITS = 16;
    localparam int FIELD_W         = 17;
    localparam int LVL_W           = FULL_SCALE_BITS + 1;
    localparam int SUM_W           = ((LVL_W > FIELD_W) ? LVL_W : FIELD_W) + 1;

    localparam logic [SUM_W-1:0] FULL_SCALE_S = SUM_W'(1) << FULL_SCALE_BITS;
    localparam logic [LVL_W-1:0] FULL_SCALE_L = LVL_W'(1) << FULL_SCALE_BITS;

    typedef enum logic [1:0] {
        STAGE_RELEASE = 2'd0,
        STAGE_ATTACK  = 2'd1,
        STAGE_DECAY   = 2'd2
    } t_stage;

    typedef struct packed {
        logic               gate;
        logic               restart;
        logic [FIELD_W-1:0] attack_step;
        logic [FIELD_W-1:0] decay_step;
        logic [FIELD_W-1:0] sustain_level;
        logic [FIELD_W-1:0] release_step;
    } t_req;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        t_stage           stage;
        logic             in_attack;
    } t_step;

endpackage

// ===== src/lae_step.sv =====
// Single-sample envelope update: restart, attack, decay/sustain, release.
// Depends on lae_pkg.
`timescale 1ns / 1ps

module lae_step (
    input  lae_pkg::t_req               i_req,
    input  logic [lae_pkg::LVL_W-1:0]   i_env,
    input  logic                        i_prev_gate,
    input  logic                        i_in_attack,
    output lae_pkg::t_step              o_step
);

    logic [lae_pkg::SUM_W-1:0] w_env;
    logic [lae_pkg::SUM_W-1:0] w_atk;
    logic [lae_pkg::SUM_W-1:0] w_dec;
    logic [lae_pkg::SUM_W-1:0] w_rel;
    logic [lae_pkg::SUM_W-1:0] w_sus_raw;
    logic [lae_pkg::SUM_W-1:0] w_sus;
    logic [lae_pkg::SUM_W-1:0] w_sum;
    logic [lae_pkg::SUM_W-1:0] w_dec_diff;
    logic [lae_pkg::SUM_W-1:0] w_rel_diff;
    logic                      w_prev;
    logic                      w_attack;

    always_comb begin
        w_env      = i_req.restart ? '0 : lae_pkg::SUM_W'(i_env);
        w_prev     = i_req.restart ? 1'b0 : i_prev_gate;
        w_atk      = lae_pkg::SUM_W'(i_req.attack_step);
        w_dec      = lae_pkg::SUM_W'(i_req.decay_step);
        w_rel      = lae_pkg::SUM_W'(i_req.release_step);
        w_sus_raw  = lae_pkg::SUM_W'(i_req.sustain_level);
        w_sus      = (w_sus_raw > lae_pkg::FULL_SCALE_S) ? lae_pkg::FULL_SCALE_S : w_sus_raw;
        w_sum      = w_env + w_atk;
        w_dec_diff = w_env - w_dec;
        w_rel_diff = w_env - w_rel;
        w_attack   = i_in_attack || (i_req.gate && !w_prev);

        o_step.in_attack = i_in_attack;
        if (i_req.gate) begin
            o_step.in_attack = w_attack;
            if (w_attack) begin
                o_step.stage = lae_pkg::STAGE_ATTACK;
                if (w_sum >= lae_pkg::FULL_SCALE_S) begin
                    o_step.level     = lae_pkg::FULL_SCALE_L;
                    o_step.in_attack = 1'b0;
                end else begin
                    o_step.level = w_sum[lae_pkg::LVL_W-1:0];
                end
            end else begin
                o_step.stage = lae_pkg::STAGE_DECAY;
                if (w_env > w_dec && w_dec_diff >= w_sus) begin
                    o_step.level = w_dec_diff[lae_pkg::LVL_W-1:0];
                end else begin
                    o_step.level = w_sus[lae_pkg::LVL_W-1:0];
                end
            end
        end else begin
            o_step.stage = lae_pkg::STAGE_RELEASE;
            o_step.level = (w_env > w_rel) ? w_rel_diff[lae_pkg::LVL_W-1:0] : '0;
        end
    end

endmodule

// ===== src/linear_adsr_envelope.sv =====
// Linear ADSR envelope generator, one sample per request. Takes one request
// every clock while o_stall is low: a request is registered in r_req, updated
// combinationally against the envelope state and held in an output register
// until taken, so the sustained rate is one sample per cycle unless i_stall
// holds a full output register; the add, compare and saturate on the level
// sit between r_req and the output register. Levels are unsigned fixed point,
// full scale 1 << FULL_SCALE_BITS (65536). Depends on lae_pkg and lae_step.
`timescale 1ns / 1ps

module linear_adsr_envelope (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_gate,
    input  logic                          i_restart,
    input  logic [lae_pkg::FIELD_W-1:0]   i_attack_step,
    input  logic [lae_pkg::FIELD_W-1:0]   i_decay_step,
    input  logic [lae_pkg::FIELD_W-1:0]   i_sustain_level,
    input  logic [lae_pkg::FIELD_W-1:0]   i_release_step,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [lae_pkg::FIELD_W-1:0]   o_level,
    output logic [1:0]                    o_stage
);

    logic                         r_in_valid;
    lae_pkg::t_req                r_req;
    logic                         r_out_valid;
    logic [lae_pkg::LVL_W-1:0]    r_out_level;
    lae_pkg::t_stage              r_out_stage;
    logic [lae_pkg::LVL_W-1:0]    r_env;
    logic                         r_prev_gate;
    logic                         r_in_attack;
    logic                         w_move;
    logic                         w_accept;
    lae_pkg::t_step               w_step;
    logic [lae_pkg::SUM_W-1:0]    w_level_ext;

    assign w_move   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall  = r_in_valid && !w_move;
    assign w_accept = i_valid && !o_stall;

    lae_step u_step (
        .i_req       (r_req),
        .i_env       (r_env),
        .i_prev_gate (r_prev_gate),
        .i_in_attack (r_in_attack),
        .o_step      (w_step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_env       <= '0;
            r_prev_gate <= 1'b0;
            r_in_attack <= 1'b0;
        end else begin
            r_in_valid <= w_accept || (r_in_valid && !w_move);
            if (w_move) begin
                r_out_valid <= 1'b1;
                r_env       <= w_step.level;
                r_prev_gate <= r_req.gate;
                r_in_attack <= w_step.in_attack;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.gate          <= i_gate;
            r_req.restart       <= i_restart;
            r_req.attack_step   <= i_attack_step;
            r_req.decay_step    <= i_decay_step;
            r_req.sustain_level <= i_sustain_level;
            r_req.release_step  <= i_release_step;
        end
        if (w_move) begin
            r_out_level <= w_step.level;
            r_out_stage <= w_step.stage;
        end
    end

    assign w_level_ext = lae_pkg::SUM_W'(r_out_level);
    assign o_valid     = r_out_valid;
    assign o_level     = w_level_ext[lae_pkg::FIELD_W-1:0];
    assign o_stage     = r_out_stage;

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_env <= lae_pkg::FULL_SCALE_L)
        else $error("envelope level above full scale");

    a_stage_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_stage == lae_pkg::STAGE_RELEASE
                         || r_out_stage == lae_pkg::STAGE_ATTACK
                         || r_out_stage == lae_pkg::STAGE_DECAY))
        else $error("unused stage code at output");

    a_attack_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && w_step.stage == lae_pkg::STAGE_ATTACK
         && w_step.level == lae_pkg::FULL_SCALE_L) |=> !r_in_attack)
        else $error("attack not ended at full scale");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled with room downstream");

    a_gate_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> (r_prev_gate == $past(r_req.gate)))
        else $error("previous gate not updated");

endmodule
